// ----- rtl/core/dptr_pkg.sv -----
// Shared types, sizes and codes for the demand paging TLB refill core.
// Used by the register block and the top level; no dependencies.
package dptr_pkg;

    localparam int PROCS               = 16;
    localparam int TEXT_PAGES_PER_PROC = 256;
    localparam int HEAP_PAGES_PER_PROC = 256;

    localparam int PAGE_BYTES = 32'h1000;
    localparam int PAIR_BITS  = 13;
    localparam int FRAME_W    = 20;
    localparam int ASID_W     = 4;
    localparam int ADDR_W     = 32;
    localparam int LO_W       = 26;

    localparam int MAX_PAGES = (TEXT_PAGES_PER_PROC > HEAP_PAGES_PER_PROC) ?
                               TEXT_PAGES_PER_PROC : HEAP_PAGES_PER_PROC;
    localparam int TEXT_DEPTH = PROCS * TEXT_PAGES_PER_PROC;
    localparam int HEAP_DEPTH = PROCS * HEAP_PAGES_PER_PROC;
    localparam int MAX_DEPTH  = PROCS * MAX_PAGES;

    localparam int TEXT_AW = $clog2(TEXT_DEPTH);
    localparam int HEAP_AW = $clog2(HEAP_DEPTH);
    localparam int TAB_AW  = $clog2(MAX_DEPTH);
    localparam int TEXT_IDX_W = $clog2(TEXT_PAGES_PER_PROC);
    localparam int HEAP_IDX_W = $clog2(HEAP_PAGES_PER_PROC);
    localparam int IDX_W      = $clog2(MAX_PAGES);

    localparam logic [ADDR_W-1:0] TEXT_SPAN = ADDR_W'(TEXT_PAGES_PER_PROC * PAGE_BYTES);
    localparam logic [ADDR_W-1:0] HEAP_SPAN = ADDR_W'(HEAP_PAGES_PER_PROC * PAGE_BYTES);

    // A table word holds a valid flag above the frame number.
    localparam int TAB_W     = FRAME_W + 1;
    localparam int VALID_BIT = FRAME_W;

    // Dirty and valid bits of an EntryLo word.
    localparam logic [5:0] LO_FLAGS = 6'b000110;

    localparam logic [ADDR_W-1:0] TEXT_BASE_RESET = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'h1000_0000;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REQ_FAULT = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] STATUS_BUILT   = 2'd0;
    localparam logic [1:0] STATUS_MISS    = 2'd1;
    localparam logic [1:0] STATUS_CLEARED = 2'd2;

    localparam logic REG_TEXT_BASE = 1'b0;
    localparam logic REG_HEAP_BASE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] text_base;
        logic [ADDR_W-1:0] heap_base;
    } dptr_cfg_t;

endpackage

// ----- rtl/core/dptr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dptr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/dptr_apb_regs.sv -----
// APB configuration registers: text and heap region base addresses.
// Depends on dptr_pkg.
module dptr_apb_regs
    import dptr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output dptr_cfg_t          cfg
);

    // Only the 8KB-aligned part of each base is stored.
    logic [ADDR_W-PAIR_BITS-1:0] text_hi_reg;
    logic [ADDR_W-PAIR_BITS-1:0] heap_hi_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_hi_reg <= TEXT_BASE_RESET[ADDR_W-1:PAIR_BITS];
            heap_hi_reg <= HEAP_BASE_RESET[ADDR_W-1:PAIR_BITS];
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TEXT_BASE: text_hi_reg <= pwdata[ADDR_W-1:PAIR_BITS];
                REG_HEAP_BASE: heap_hi_reg <= pwdata[ADDR_W-1:PAIR_BITS];
                default: ;
            endcase
        end
    end

    assign cfg.text_base = {text_hi_reg, {PAIR_BITS{1'b0}}};
    assign cfg.heap_base = {heap_hi_reg, {PAIR_BITS{1'b0}}};

    always_comb begin
        unique case (paddr[2])
            REG_TEXT_BASE: prdata = cfg.text_base;
            REG_HEAP_BASE: prdata = cfg.heap_base;
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/demand_paging_tlb_refill_core.sv -----
// Demand paging TLB refill core: region decode, per-process page table
// read-modify-write and result register. Depends on dptr_pkg, dptr_ram, dptr_apb_regs.
//
//  Channel  Direction  tdata (low bit up)                       tuser
//  s_       in         asid, fault_addr                         req_type
//  m_       out        entry_hi, entry_lo_even, entry_lo_odd,   status
//                      even_fresh, odd_fresh, in_text
//  APB      in/out     region base registers at 0x0 and 0x4     -
//
// A fault goes from acceptance through the class, even read, odd read, odd and done
// steps before the next acceptance; a miss goes from the class step straight to done.
// The even and odd table entries are read one after the other over the single read
// port of each table, and an invalid one is written back with a new frame. A clear
// walks one process row, MAX_PAGES entries, one a cycle. After reset a clearing pass
// writes every table entry invalid while s_tready stays low. A stalled result holds
// the core in its last step until the result is taken.
module demand_paging_tlb_refill_core
    import dptr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // asid[3:0], fault_addr[35:4], zero pad
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // entry_hi[31:0], entry_lo_even[57:32],
                                             // entry_lo_odd[83:58], even_fresh[84],
                                             // odd_fresh[85], in_text[86], zero pad
    output logic [1:0]            m_tuser,   // status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CLASS,
        ST_CLEAR,
        ST_RD_E,
        ST_RD_O,
        ST_ODD,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    dptr_cfg_t               cfg;
    logic [TAB_AW-1:0]       cnt_reg;
    logic                    req_reg;
    logic [ASID_W-1:0]       asid_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    is_text_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    odd_ok_reg;
    logic [1:0]              status_reg;
    logic [FRAME_W-1:0]      next_frame_reg;
    logic [FRAME_W-1:0]      fe_reg;
    logic [FRAME_W-1:0]      fo_reg;
    logic                    fe_fresh_reg;
    logic                    fo_fresh_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic [ADDR_W-1:0]       text_off;
    logic [ADDR_W-1:0]       heap_off;
    logic                    text_hit;
    logic                    heap_hit;
    logic                    asid_ok;
    logic [IDX_W-1:0]        idx_sel;
    logic                    odd_ok_sel;
    logic [TAB_AW-1:0]       pages_sel;
    logic [TAB_AW-1:0]       even_addr;
    logic [TAB_AW-1:0]       odd_addr;
    logic [TAB_AW-1:0]       t_clr_addr;
    logic [TAB_AW-1:0]       h_clr_addr;
    logic [TAB_AW-1:0]       t_waddr;
    logic [TAB_AW-1:0]       h_waddr;
    logic [TAB_AW-1:0]       raddr;
    logic [TAB_W-1:0]        wdata;
    logic                    t_we;
    logic                    h_we;
    logic                    t_re;
    logic                    h_re;
    logic [TAB_W-1:0]        t_rdata;
    logic [TAB_W-1:0]        h_rdata;
    logic [TAB_W-1:0]        rd_word;
    logic [ADDR_W-1:0]       entry_hi;
    logic [LO_W-1:0]         lo_even;
    logic [LO_W-1:0]         lo_odd;

    dptr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dptr_ram #(.WIDTH(TAB_W), .DEPTH(TEXT_DEPTH)) u_text_tab (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr[TEXT_AW-1:0]),
        .wdata (wdata),
        .re    (t_re),
        .raddr (raddr[TEXT_AW-1:0]),
        .rdata (t_rdata)
    );

    dptr_ram #(.WIDTH(TAB_W), .DEPTH(HEAP_DEPTH)) u_heap_tab (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr[HEAP_AW-1:0]),
        .wdata (wdata),
        .re    (h_re),
        .raddr (raddr[HEAP_AW-1:0]),
        .rdata (h_rdata)
    );

    // Region decode on the captured request. Text wins where the regions overlap.
    assign text_off = addr_reg - cfg.text_base;
    assign heap_off = addr_reg - cfg.heap_base;
    assign text_hit = (addr_reg >= cfg.text_base) && (text_off < TEXT_SPAN);
    assign heap_hit = (addr_reg >= cfg.heap_base) && (heap_off < HEAP_SPAN);
    assign asid_ok  = int'(asid_reg) < PROCS;

    always_comb begin
        if (text_hit) begin
            idx_sel    = IDX_W'(text_off[PAIR_BITS-1 +: TEXT_IDX_W]) & ~IDX_W'(1);
            odd_ok_sel = (int'(idx_sel) + 1) < TEXT_PAGES_PER_PROC;
        end else begin
            idx_sel    = IDX_W'(heap_off[PAIR_BITS-1 +: HEAP_IDX_W]) & ~IDX_W'(1);
            odd_ok_sel = (int'(idx_sel) + 1) < HEAP_PAGES_PER_PROC;
        end
    end

    assign pages_sel  = is_text_reg ? TAB_AW'(TEXT_PAGES_PER_PROC) :
                                      TAB_AW'(HEAP_PAGES_PER_PROC);
    assign even_addr  = TAB_AW'(asid_reg) * pages_sel + TAB_AW'(idx_reg);
    assign odd_addr   = even_addr + TAB_AW'(1);
    assign t_clr_addr = TAB_AW'(asid_reg) * TAB_AW'(TEXT_PAGES_PER_PROC) + cnt_reg;
    assign h_clr_addr = TAB_AW'(asid_reg) * TAB_AW'(HEAP_PAGES_PER_PROC) + cnt_reg;
    assign rd_word    = is_text_reg ? t_rdata : h_rdata;

    assign raddr = (state_reg == ST_RD_E) ? even_addr : odd_addr;
    assign t_re  = is_text_reg && ((state_reg == ST_RD_E) || (state_reg == ST_RD_O));
    assign h_re  = !is_text_reg && ((state_reg == ST_RD_E) || (state_reg == ST_RD_O));

    // Table write port: reset sweep, process clear, or allocation of a missing page.
    always_comb begin
        t_we    = 1'b0;
        h_we    = 1'b0;
        t_waddr = even_addr;
        h_waddr = even_addr;
        wdata   = {1'b1, next_frame_reg};
        unique case (state_reg)
            ST_SWEEP: begin
                t_we    = int'(cnt_reg) < TEXT_DEPTH;
                h_we    = int'(cnt_reg) < HEAP_DEPTH;
                t_waddr = cnt_reg;
                h_waddr = cnt_reg;
                wdata   = '0;
            end
            ST_CLEAR: begin
                t_we    = asid_ok && (int'(cnt_reg) < TEXT_PAGES_PER_PROC);
                h_we    = asid_ok && (int'(cnt_reg) < HEAP_PAGES_PER_PROC);
                t_waddr = t_clr_addr;
                h_waddr = h_clr_addr;
                wdata   = '0;
            end
            ST_RD_O: begin
                t_we = is_text_reg && !rd_word[VALID_BIT];
                h_we = !is_text_reg && !rd_word[VALID_BIT];
            end
            ST_ODD: begin
                t_we    = is_text_reg && odd_ok_reg && !rd_word[VALID_BIT];
                h_we    = !is_text_reg && odd_ok_reg && !rd_word[VALID_BIT];
                t_waddr = odd_addr;
                h_waddr = odd_addr;
            end
            default: ;
        endcase
    end

    assign entry_hi = {addr_reg[ADDR_W-1:PAIR_BITS], {(PAIR_BITS-ASID_W){1'b0}}, asid_reg};
    assign lo_even  = {fe_reg, LO_FLAGS};
    assign lo_odd   = {fo_reg, LO_FLAGS};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            cnt_reg        <= '0;
            next_frame_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // In the last step the result register is handled below.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SWEEP: begin
                    cnt_reg <= cnt_reg + TAB_AW'(1);
                    if (cnt_reg == TAB_AW'(MAX_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg   <= s_tuser;
                        asid_reg  <= s_tdata[ASID_W-1:0];
                        addr_reg  <= s_tdata[ASID_W +: ADDR_W];
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    cnt_reg      <= '0;
                    is_text_reg  <= text_hit;
                    idx_reg      <= idx_sel;
                    odd_ok_reg   <= odd_ok_sel;
                    fe_fresh_reg <= 1'b0;
                    fo_fresh_reg <= 1'b0;
                    if (req_reg == REQ_CLEAR) begin
                        status_reg <= STATUS_CLEARED;
                        state_reg  <= ST_CLEAR;
                    end else if (!asid_ok || !(text_hit || heap_hit)) begin
                        status_reg <= STATUS_MISS;
                        state_reg  <= ST_DONE;
                    end else begin
                        status_reg <= STATUS_BUILT;
                        state_reg  <= ST_RD_E;
                    end
                end
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + TAB_AW'(1);
                    if (cnt_reg == TAB_AW'(MAX_PAGES - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RD_E: begin
                    state_reg <= ST_RD_O;
                end
                ST_RD_O: begin
                    if (rd_word[VALID_BIT]) begin
                        fe_reg <= rd_word[FRAME_W-1:0];
                    end else begin
                        fe_reg         <= next_frame_reg;
                        fe_fresh_reg   <= 1'b1;
                        next_frame_reg <= next_frame_reg + FRAME_W'(1);
                    end
                    state_reg <= ST_ODD;
                end
                ST_ODD: begin
                    // A pair at the end of the region maps its odd half to the even frame.
                    if (!odd_ok_reg) begin
                        fo_reg <= fe_reg;
                    end else if (rd_word[VALID_BIT]) begin
                        fo_reg <= rd_word[FRAME_W-1:0];
                    end else begin
                        fo_reg         <= next_frame_reg;
                        fo_fresh_reg   <= 1'b1;
                        next_frame_reg <= next_frame_reg + FRAME_W'(1);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        if (status_reg == STATUS_BUILT) begin
                            m_tdata_reg <= {1'b0, is_text_reg, fo_fresh_reg, fe_fresh_reg,
                                            lo_odd, lo_even, entry_hi};
                        end else begin
                            m_tdata_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while one is in flight");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_BUILT) |-> (m_tdata == '0))
        else $error("miss or clear result carries nonzero fields");

    a_frame_bump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_O) && (t_we || h_we)
        |=> next_frame_reg == FRAME_W'($past(next_frame_reg) + 1))
        else $error("even page allocation did not advance the frame counter");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(t_we || h_we))
        else $error("table written while idle");

endmodule

// ----- tb/tlb_refill_checker.sv -----
// Checker for the demand paging TLB refill core: watches the request, result and
// register channels, keeps its own page tables and compares every result.
// Depends on dptr_pkg.
module tlb_refill_checker
    import dptr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] entry_hi;
        logic [LO_W-1:0]   lo_even;
        logic [LO_W-1:0]   lo_odd;
        logic              even_fresh;
        logic              odd_fresh;
        logic              in_text;
    } refill_entry_t;

    logic [FRAME_W-1:0] text_map [TEXT_DEPTH];
    bit                 text_live [TEXT_DEPTH];
    logic [FRAME_W-1:0] heap_map [HEAP_DEPTH];
    bit                 heap_live [HEAP_DEPTH];
    logic [FRAME_W-1:0] frame_ctr;
    logic [ADDR_W-1:0]  text_base;
    logic [ADDR_W-1:0]  heap_base;

    refill_entry_t entries_due[$];
    refill_entry_t want;
    refill_entry_t seen;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Returns the frame of one page, taking the next free frame if it has none yet.
    function automatic logic [FRAME_W-1:0] claim_frame(input bit text_side, input int slot,
                                                       output bit fresh);
        logic [FRAME_W-1:0] got;
        if (text_side ? text_live[slot] : heap_live[slot]) begin
            fresh = 1'b0;
            return text_side ? text_map[slot] : heap_map[slot];
        end
        got   = frame_ctr;
        fresh = 1'b1;
        if (text_side) begin
            text_map[slot]  = got;
            text_live[slot] = 1'b1;
        end else begin
            heap_map[slot]  = got;
            heap_live[slot] = 1'b1;
        end
        frame_ctr = frame_ctr + 1'b1;
        return got;
    endfunction

    function automatic bit covers(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] base,
                                  input int pages);
        return (addr >= base) && (64'(addr - base) < 64'(pages) * 64'(PAGE_BYTES));
    endfunction

    function automatic refill_entry_t service_request(input logic req,
                                                      input logic [ASID_W-1:0] asid,
                                                      input logic [ADDR_W-1:0] addr);
        refill_entry_t     r;
        bit                text_side;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] pair;
        int                pages;
        int                idx;
        int                row;
        int                p;
        logic [FRAME_W-1:0] fe;
        logic [FRAME_W-1:0] fo;
        bit                fe_new;
        bit                fo_new;
        r = '0;
        if (req == REQ_CLEAR) begin
            if (int'(asid) < PROCS) begin
                for (p = 0; p < TEXT_PAGES_PER_PROC; p++)
                    text_live[int'(asid) * TEXT_PAGES_PER_PROC + p] = 1'b0;
                for (p = 0; p < HEAP_PAGES_PER_PROC; p++)
                    heap_live[int'(asid) * HEAP_PAGES_PER_PROC + p] = 1'b0;
            end
            r.status = STATUS_CLEARED;
            return r;
        end
        if (int'(asid) >= PROCS) begin
            r.status = STATUS_MISS;
            return r;
        end
        // Text wins where the two regions overlap.
        if (covers(addr, text_base, TEXT_PAGES_PER_PROC)) begin
            text_side = 1'b1;
            base      = text_base;
            pages     = TEXT_PAGES_PER_PROC;
        end else if (covers(addr, heap_base, HEAP_PAGES_PER_PROC)) begin
            text_side = 1'b0;
            base      = heap_base;
            pages     = HEAP_PAGES_PER_PROC;
        end else begin
            r.status = STATUS_MISS;
            return r;
        end
        pair   = {addr[ADDR_W-1:PAIR_BITS], PAIR_BITS'(0)};
        idx    = int'((pair - base) >> $clog2(PAGE_BYTES));
        row    = int'(asid) * pages;
        fe     = claim_frame(text_side, row + idx, fe_new);
        fo_new = 1'b0;
        // An odd page beyond the region end mirrors the even page.
        if (idx + 1 < pages)
            fo = claim_frame(text_side, row + idx + 1, fo_new);
        else
            fo = fe;
        r.status     = STATUS_BUILT;
        r.entry_hi   = pair | ADDR_W'(asid);
        r.lo_even    = {fe, LO_FLAGS};
        r.lo_odd     = {fo, LO_FLAGS};
        r.even_fresh = fe_new;
        r.odd_fresh  = fo_new;
        r.in_text    = text_side;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TEXT_DEPTH; i++) text_live[i] = 1'b0;
            for (int i = 0; i < HEAP_DEPTH; i++) heap_live[i] = 1'b0;
            frame_ctr = '0;
            text_base = TEXT_BASE_RESET;
            heap_base = HEAP_BASE_RESET;
            entries_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                entries_due.push_back(service_request(s_tuser, s_tdata[ASID_W-1:0],
                                                      s_tdata[ASID_W +: ADDR_W]));
            if (m_tvalid && m_tready) begin
                seen.status     = m_tuser;
                seen.entry_hi   = m_tdata[31:0];
                seen.lo_even    = m_tdata[57:32];
                seen.lo_odd     = m_tdata[83:58];
                seen.even_fresh = m_tdata[84];
                seen.odd_fresh  = m_tdata[85];
                seen.in_text    = m_tdata[86];
                if (entries_due.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual 0x%0h",
                             $time, seen);
                    mismatches++;
                end else begin
                    want = entries_due.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("entry_hi", want.entry_hi, seen.entry_hi);
                    check_field("entry_lo_even", 32'(want.lo_even), 32'(seen.lo_even));
                    check_field("entry_lo_odd", 32'(want.lo_odd), 32'(seen.lo_odd));
                    check_field("even_fresh", 32'(want.even_fresh), 32'(seen.even_fresh));
                    check_field("odd_fresh", 32'(want.odd_fresh), 32'(seen.odd_fresh));
                    check_field("in_text", 32'(want.in_text), 32'(seen.in_text));
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[PADDR_W-1:2] == REG_HEAP_BASE)
                    heap_base = {pwdata[ADDR_W-1:PAIR_BITS], PAIR_BITS'(0)};
                else
                    text_base = {pwdata[ADDR_W-1:PAIR_BITS], PAIR_BITS'(0)};
            end
        end
        outstanding <= entries_due.size();
    end

endmodule

// ----- tb/tb_demand_paging_tlb_refill_core.sv -----
// Top of the refill core testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on dptr_pkg, the core and
// tlb_refill_checker.
module tb_demand_paging_tlb_refill_core;
    import dptr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 96;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;    // asid[3:0], fault_addr[35:4], zero pad
    logic                  s_tuser  = REQ_FAULT;   // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // entry_hi, entry_lo_even, entry_lo_odd,
                                             // even_fresh, odd_fresh, in_text, zero pad
    logic [1:0]            m_tuser;          // status
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int          mismatches;
    int          outstanding;
    int unsigned cycles = 0;
    bit          quiet_tail = 1'b0;
    logic [ADDR_W-1:0] text_base_now = TEXT_BASE_RESET;
    logic [ADDR_W-1:0] heap_base_now = HEAP_BASE_RESET;

    demand_paging_tlb_refill_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tlb_refill_checker refill_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Result side: ready runs of random length broken by stall bursts, except once quiet_tail is set.
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            if (!quiet_tail) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge aclk);
            end
        end
    end

    task automatic send(input logic req, input logic [ASID_W-1:0] asid,
                        input logic [ADDR_W-1:0] addr);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, addr, asid};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits until every result has been taken.
    task automatic settle;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_base(input logic idx, input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_HEAP_BASE)
            heap_base_now = {value[ADDR_W-1:PAIR_BITS], PAIR_BITS'(0)};
        else
            text_base_now = {value[ADDR_W-1:PAIR_BITS], PAIR_BITS'(0)};
    endtask

    // Mostly faults inside a region, bunched on a few processes and low pages so
    // that pages get reused; the rest are clears and addresses anywhere.
    task automatic issue_random;
        int                pick;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] offset;
        logic [ASID_W-1:0] asid;
        pick = $urandom_range(0, 99);
        asid = ($urandom_range(0, 1) != 0) ? ASID_W'($urandom_range(0, 3)) : ASID_W'($urandom);
        if (pick < 4) begin
            send(REQ_CLEAR, asid, $urandom);
        end else if (pick < 82) begin
            if ($urandom_range(0, 1) != 0) begin
                base = text_base_now;
                span = TEXT_SPAN;
            end else begin
                base = heap_base_now;
                span = HEAP_SPAN;
            end
            if ($urandom_range(0, 1) != 0)
                offset = $urandom_range(0, 15) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
            else
                offset = $urandom_range(0, span - 1);
            send(REQ_FAULT, asid, base + offset);
        end else begin
            send(REQ_FAULT, asid, $urandom);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] shared;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // The core clears its tables after reset before it takes requests.
        do @(posedge aclk); while (!s_tready);

        write_base(REG_TEXT_BASE, 32'h0040_1234);
        write_base(REG_HEAP_BASE, 32'h1000_1FFF);
        send(REQ_FAULT, 4'd0, 32'h0040_0000);
        send(REQ_FAULT, 4'd0, 32'h0040_1ABC);
        send(REQ_FAULT, 4'd0, text_base_now + TEXT_SPAN - 1);
        send(REQ_FAULT, 4'd0, text_base_now + TEXT_SPAN);
        send(REQ_FAULT, 4'd0, text_base_now - 1);
        send(REQ_FAULT, 4'd15, heap_base_now);
        send(REQ_FAULT, 4'd15, heap_base_now + HEAP_SPAN - 1);
        send(REQ_FAULT, 4'd5, 32'h0000_0000);
        send(REQ_FAULT, 4'd10, 32'hFFFF_FFFF);
        send(REQ_FAULT, 4'd15, heap_base_now + 32'h2000);
        send(REQ_CLEAR, 4'd0, 32'hFFFF_FFFF);
        send(REQ_FAULT, 4'd0, 32'h0040_0000);
        send(REQ_CLEAR, 4'd15, 32'h0000_0000);
        send(REQ_FAULT, 4'd15, heap_base_now);
        send(REQ_CLEAR, 4'd9, 32'h1234_5678);
        settle();

        write_base(REG_TEXT_BASE, 32'hFFFF_FFFF);
        write_base(REG_HEAP_BASE, 32'h0000_0000);
        send(REQ_FAULT, 4'd3, 32'hFFFF_FFFF);
        send(REQ_FAULT, 4'd3, 32'hFFFF_E000);
        send(REQ_FAULT, 4'd3, 32'h0000_0000);
        send(REQ_FAULT, 4'd3, HEAP_SPAN - 1);
        send(REQ_FAULT, 4'd3, HEAP_SPAN);
        send(REQ_FAULT, 4'd12, 32'hFFFF_DFFF);
        settle();

        // Both regions at one base: the text region takes precedence.
        write_base(REG_TEXT_BASE, 32'h2000_0000);
        write_base(REG_HEAP_BASE, 32'h2000_0000);
        send(REQ_FAULT, 4'd7, 32'h2000_0000);
        send(REQ_FAULT, 4'd7, 32'h2000_0000 + TEXT_SPAN - 1);
        send(REQ_CLEAR, 4'd7, 32'h0000_0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            shared = $urandom;
            case (p)
                0: begin
                    write_base(REG_TEXT_BASE, TEXT_BASE_RESET);
                    write_base(REG_HEAP_BASE, HEAP_BASE_RESET);
                end
                1: begin
                    write_base(REG_TEXT_BASE, 32'h0000_0000);
                    write_base(REG_HEAP_BASE, 32'hFFFF_FFFF);
                end
                2: begin
                    write_base(REG_TEXT_BASE, shared);
                    write_base(REG_HEAP_BASE, shared);
                end
                3: begin
                    write_base(REG_TEXT_BASE, shared);
                    write_base(REG_HEAP_BASE, shared + $urandom_range(0, TEXT_SPAN));
                end
                default: begin
                    write_base(REG_TEXT_BASE, $urandom);
                    write_base(REG_HEAP_BASE, $urandom);
                end
            endcase
            quiet_tail = (p == RANDOM_PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                issue_random();
                if (p == 1 && k == PHASE_ITEMS / 2)
                    settle();
            end
        end

        settle();
        repeat (300) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- demand_paging_tlb_refill_core.f -----
rtl/core/dptr_pkg.sv
rtl/core/dptr_ram.sv
rtl/core/dptr_apb_regs.sv
rtl/core/demand_paging_tlb_refill_core.sv
tb/tlb_refill_checker.sv
tb/tb_demand_paging_tlb_refill_core.sv
